FILE: rtl/nictd_pkg.sv
// Shared types, widths and constants for the NIC transfer delay model.
// Holds the request/result structs, register indexes and the divide-by-1000 digit step.
// No dependencies.
package nictd_pkg;

    // Field and register widths
    localparam int SETUP_W    = 48;
    localparam int NPB_W      = 32;
    localparam int MIN_W      = 32;
    localparam int BYTES_W    = 24;
    localparam int DELAY_W    = 32;
    localparam int CNT_W      = 64;
    localparam int CFG_DATA_W = 48;
    localparam int CFG_IDX_W  = 2;

    // setup + bytes * ns_per_byte stays below 2^57
    localparam int COST_W = 57;

    // Radix-256 long division by 1000
    localparam int DIG_W   = 8;
    localparam int REM_W   = 10;
    localparam int VAL_W   = REM_W + DIG_W;
    localparam int RECIP_W = 9;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((1 << VAL_W) / 1000);
    localparam logic [VAL_W-1:0]   NS_PER_US = VAL_W'(1000);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SETUP       = 2'd0,
        CFG_NS_PER_BYTE = 2'd1,
        CFG_MIN_DELAY   = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic               is_read;
        logic [BYTES_W-1:0] byte_count;
    } in_t;

    typedef struct packed {
        logic [DELAY_W-1:0] delay_us;
        logic [CNT_W-1:0]   direction_packets;
        logic [CNT_W-1:0]   direction_total_delay;
        logic [CNT_W-1:0]   direction_total_bytes;
    } out_t;

    typedef struct packed {
        logic [DIG_W-1:0] quot;
        logic [REM_W-1:0] rem;
    } div_step_t;

    // One long-division digit: ({rem_in, digit}) / 1000, rem_in below 1000.
    // The reciprocal estimate is at most one low; a single compare fixes it.
    function automatic div_step_t div_step(input logic [REM_W-1:0] rem_in,
                                           input logic [DIG_W-1:0] digit);
        logic [VAL_W-1:0]         val;
        logic [VAL_W+RECIP_W-1:0] prod;
        logic [DIG_W-1:0]         q_est;
        logic [VAL_W-1:0]         q_ext;
        logic [VAL_W-1:0]         r_est;
        div_step_t                res;
        val   = {rem_in, digit};
        prod  = (VAL_W+RECIP_W)'(val) * (VAL_W+RECIP_W)'(RECIP);
        q_est = prod[VAL_W +: DIG_W];
        q_ext = VAL_W'(q_est);
        // q * 1000 = q*1024 - q*16 - q*8
        r_est = val - ((q_ext << 10) - (q_ext << 4) - (q_ext << 3));
        if (r_est >= NS_PER_US) begin
            res.quot = q_est + 1'b1;
            res.rem  = REM_W'(r_est - NS_PER_US);
        end else begin
            res.quot = q_est;
            res.rem  = r_est[REM_W-1:0];
        end
        return res;
    endfunction

endpackage

FILE: rtl/nic_transfer_delay_model.sv
// NIC transfer delay model: costs each packet request and charges a delay in microseconds.
// Uses nictd_pkg for payload structs, register indexes and the division digit step.
//
// Stages: input register, cost stage, division stages (one per 8-bit digit of the integer cost),
// prep stage, result register. Throughput: one request per cycle unless m_ready stalls the
// result; the residual update stage retires one request each cycle, earlier stages feed forward.
// Reset (aresetn low, synchronous): residuals and all totals cleared, pipeline emptied,
// registers return to setup 0, 8 ns/byte, minimum delay 0.
module nic_transfer_delay_model #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [nictd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [nictd_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  nictd_pkg::in_t                      s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output nictd_pkg::out_t                     m_data
);

    localparam int XW   = nictd_pkg::COST_W - FRAC_BITS;
    localparam int DW   = nictd_pkg::DIG_W;
    localparam int NDIG = (XW + DW - 1) / DW;
    localparam int XP   = NDIG * DW;
    localparam int QW   = 64 - FRAC_BITS;
    localparam int RW   = FRAC_BITS + 10;
    localparam int CW   = nictd_pkg::CNT_W;

    localparam logic [63:0]   ONE_US_64  = 64'd1000 << FRAC_BITS;
    localparam logic [63:0]   HALF_US_64 = 64'd500 << FRAC_BITS;
    localparam logic [RW-1:0] ONE_US     = ONE_US_64[RW-1:0];
    localparam logic [RW-1:0] HALF_US    = HALF_US_64[RW-1:0];

    // Most negative residual (-2^63 in Q.F ns) as quotient/remainder of one microsecond
    localparam logic [63:0] SAT_P    = 64'd1 << (63 - FRAC_BITS);
    localparam logic [63:0] SAT_CEIL = (SAT_P + 64'd999) / 64'd1000;
    localparam logic [63:0] SAT_R64  = (SAT_CEIL * 64'd1000 - SAT_P) << FRAC_BITS;
    localparam logic signed [QW-1:0] SAT_Q = QW'(64'd0 - SAT_CEIL);
    localparam logic [RW-1:0]        SAT_R = SAT_R64[RW-1:0];

    localparam logic signed [QW-1:0] Q_ONE     = QW'(1);
    localparam logic signed [QW-1:0] Q_NEG_ONE = QW'(64'hFFFF_FFFF_FFFF_FFFF);
    localparam logic signed [QW-1:0] US_MAX_Q  = QW'(64'hFFFF_FFFF);
    localparam logic [nictd_pkg::DELAY_W-1:0] US_MAX = '1;

    // Configuration registers
    logic [nictd_pkg::SETUP_W-1:0] setup_reg;
    logic [nictd_pkg::NPB_W-1:0]   npb_reg;
    logic [nictd_pkg::MIN_W-1:0]   min_reg;

    // Input stage
    logic           in_v_reg;
    nictd_pkg::in_t in_data_reg;

    // Cost stage (index 0) and division stages (1..NDIG)
    logic [NDIG:0]                   dv_reg;
    logic [NDIG:0]                   dadv;
    logic                            drd_reg  [0:NDIG];
    logic [nictd_pkg::BYTES_W-1:0]   dby_reg  [0:NDIG];
    logic [FRAC_BITS-1:0]            dlo_reg  [0:NDIG];
    logic [XP-1:0]                   dq_reg   [0:NDIG];
    logic [nictd_pkg::REM_W-1:0]     drem_reg [0:NDIG];
    logic [XP-1:0]                   dx_reg   [0:NDIG-1];

    // Prep stage
    logic                          pv_reg;
    logic                          p_rd_reg;
    logic [nictd_pkg::BYTES_W-1:0] p_by_reg;
    logic [QW-1:0]                 p_cq_reg;
    logic [RW-1:0]                 p_cr_reg;
    logic signed [QW-1:0]          p_dmin_reg;
    logic signed [QW-1:0]          p_dsat_reg;

    // Per-direction state, index 1 = read
    logic signed [QW-1:0] rq_reg [0:1];
    logic [RW-1:0]        rr_reg [0:1];
    logic [CW-1:0]        pk_reg [0:1];
    logic [CW-1:0]        dl_reg [0:1];
    logic [CW-1:0]        by_reg [0:1];

    // Output register
    logic            m_valid_reg;
    nictd_pkg::out_t m_data_reg;

    logic in_adv;
    logic prep_adv;
    logic out_adv;

    // Per-stage advance: a stage moves when empty or when the next one moves
    always_comb begin
        out_adv  = !m_valid_reg || m_ready;
        prep_adv = !pv_reg || out_adv;
        dadv[NDIG] = !dv_reg[NDIG] || prep_adv;
        for (int j = NDIG - 1; j >= 0; j--) begin
            dadv[j] = !dv_reg[j] || dadv[j+1];
        end
        in_adv = !in_v_reg || dadv[0];
    end

    assign s_ready = in_adv;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Packet cost in Q.F ns
    logic [nictd_pkg::BYTES_W+nictd_pkg::NPB_W-1:0] byte_cost;
    logic [nictd_pkg::COST_W-1:0]                   cost;

    always_comb begin
        byte_cost = (nictd_pkg::BYTES_W+nictd_pkg::NPB_W)'(in_data_reg.byte_count)
                  * (nictd_pkg::BYTES_W+nictd_pkg::NPB_W)'(npb_reg);
        cost = nictd_pkg::COST_W'(setup_reg) + nictd_pkg::COST_W'(byte_cost);
    end

    // Prep: cost quotient and remainder of one microsecond, plus offsets
    logic [QW-1:0] cq;
    assign cq = QW'(dq_reg[NDIG]);

    // Residual update
    logic signed [QW-1:0] rq_cur;
    logic [RW-1:0]        rr_cur;
    logic [RW:0]          sum_r;
    logic                 carry;
    logic [RW-1:0]        r_pos;
    logic signed [QW-1:0] q_pos;
    logic signed [QW-1:0] q_round;
    logic signed [QW-1:0] rq_low;
    logic signed [QW-1:0] rq_sat;
    logic                 over_us;
    logic                 rnd;
    logic                 us_sat;
    logic [nictd_pkg::DELAY_W-1:0] us;
    logic signed [QW-1:0] rq_new;
    logic [RW-1:0]        rr_new;
    logic [CW-1:0]        pk_new;
    logic [CW-1:0]        dl_new;
    logic [CW-1:0]        by_new;

    always_comb begin
        rq_cur  = rq_reg[p_rd_reg];
        rr_cur  = rr_reg[p_rd_reg];
        sum_r   = {1'b0, rr_cur} + {1'b0, p_cr_reg};
        carry   = sum_r >= {1'b0, ONE_US};
        r_pos   = carry ? RW'(sum_r - {1'b0, ONE_US}) : sum_r[RW-1:0];
        q_pos   = rq_cur + $signed(p_cq_reg) + $signed(QW'(carry));
        // residual above one microsecond
        over_us = (q_pos > Q_ONE) || ((q_pos == Q_ONE) && (r_pos != '0));
        rnd     = r_pos >= HALF_US;
        q_round = q_pos + $signed(QW'(rnd));
        us_sat  = q_round > US_MAX_Q;
        rq_low  = rq_cur + p_dmin_reg + $signed(QW'(carry));
        rq_sat  = rq_cur + p_dsat_reg + $signed(QW'(carry));
        rr_new  = r_pos;
        if (over_us) begin
            if (us_sat) begin
                us     = US_MAX;
                rq_new = rq_sat;
            end else begin
                us     = q_round[nictd_pkg::DELAY_W-1:0];
                rq_new = rnd ? Q_NEG_ONE : '0;
            end
        end else begin
            us     = min_reg;
            rq_new = rq_low;
            // clamp at the most negative residual
            if ((rq_low < SAT_Q) || ((rq_low == SAT_Q) && (r_pos < SAT_R))) begin
                rq_new = SAT_Q;
                rr_new = SAT_R;
            end
        end
        pk_new = pk_reg[p_rd_reg] + CW'(1);
        dl_new = dl_reg[p_rd_reg] + CW'(us);
        by_new = by_reg[p_rd_reg] + CW'(p_by_reg);
    end

    // Control state, configuration and per-direction state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            setup_reg   <= '0;
            npb_reg     <= nictd_pkg::NPB_W'(64'd8 << FRAC_BITS);
            min_reg     <= '0;
            in_v_reg    <= 1'b0;
            dv_reg      <= '0;
            pv_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int d = 0; d < 2; d++) begin
                rq_reg[d] <= '0;
                rr_reg[d] <= '0;
                pk_reg[d] <= '0;
                dl_reg[d] <= '0;
                by_reg[d] <= '0;
            end
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    nictd_pkg::CFG_SETUP:       setup_reg <= cfg_wdata;
                    nictd_pkg::CFG_NS_PER_BYTE: npb_reg   <= cfg_wdata[nictd_pkg::NPB_W-1:0];
                    nictd_pkg::CFG_MIN_DELAY:   min_reg   <= cfg_wdata[nictd_pkg::MIN_W-1:0];
                    default: ;
                endcase
            end
            if (in_adv) begin
                in_v_reg <= s_valid;
            end
            if (dadv[0]) begin
                dv_reg[0] <= in_v_reg;
            end
            for (int j = 1; j <= NDIG; j++) begin
                if (dadv[j]) begin
                    dv_reg[j] <= dv_reg[j-1];
                end
            end
            if (prep_adv) begin
                pv_reg <= dv_reg[NDIG];
            end
            if (out_adv) begin
                m_valid_reg <= pv_reg;
                if (pv_reg) begin
                    rq_reg[p_rd_reg] <= rq_new;
                    rr_reg[p_rd_reg] <= rr_new;
                    pk_reg[p_rd_reg] <= pk_new;
                    dl_reg[p_rd_reg] <= dl_new;
                    by_reg[p_rd_reg] <= by_new;
                end
            end
        end
    end

    // Payload: input and cost stages
    always_ff @(posedge aclk) begin
        if (in_adv && s_valid) begin
            in_data_reg <= s_data;
        end
        if (dadv[0] && in_v_reg) begin
            drd_reg[0]  <= in_data_reg.is_read;
            dby_reg[0]  <= in_data_reg.byte_count;
            dlo_reg[0]  <= cost[FRAC_BITS-1:0];
            dx_reg[0]   <= XP'(cost[nictd_pkg::COST_W-1:FRAC_BITS]);
            dq_reg[0]   <= '0;
            drem_reg[0] <= '0;
        end
    end

    // Division stages: one radix-256 quotient digit per stage, most significant first
    for (genvar j = 1; j <= NDIG; j++) begin : g_div
        nictd_pkg::div_step_t step;
        assign step = nictd_pkg::div_step(drem_reg[j-1], dx_reg[j-1][XP-1 -: DW]);

        always_ff @(posedge aclk) begin
            if (dadv[j] && dv_reg[j-1]) begin
                drd_reg[j]  <= drd_reg[j-1];
                dby_reg[j]  <= dby_reg[j-1];
                dlo_reg[j]  <= dlo_reg[j-1];
                dq_reg[j]   <= {dq_reg[j-1][XP-DW-1:0], step.quot};
                drem_reg[j] <= step.rem;
            end
        end

        if (j < NDIG) begin : g_shift
            always_ff @(posedge aclk) begin
                if (dadv[j] && dv_reg[j-1]) begin
                    dx_reg[j] <= dx_reg[j-1] << DW;
                end
            end
        end
    end

    // Payload: prep stage and result register
    always_ff @(posedge aclk) begin
        if (prep_adv && dv_reg[NDIG]) begin
            p_rd_reg   <= drd_reg[NDIG];
            p_by_reg   <= dby_reg[NDIG];
            p_cq_reg   <= cq;
            p_cr_reg   <= {drem_reg[NDIG], dlo_reg[NDIG]};
            p_dmin_reg <= $signed(cq) - $signed(QW'(min_reg));
            p_dsat_reg <= $signed(cq) - US_MAX_Q;
        end
        if (out_adv && pv_reg) begin
            m_data_reg.delay_us              <= us;
            m_data_reg.direction_packets     <= pk_new;
            m_data_reg.direction_total_delay <= dl_new;
            m_data_reg.direction_total_bytes <= by_new;
        end
    end

endmodule

FILE: rtl/nictd_checker.sv
// Port-level checks for the NIC transfer delay model, bound to the top level.
// Depends on nictd_pkg for the request/result structs.
module nictd_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_ready,
    input logic                             m_valid,
    input logic                             m_ready,
    input nictd_pkg::out_t                  m_data
);

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    // Input only backs up when the result side is stalled
    a_no_block: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("request refused while result side is free");

    // First packet of a direction: total delay equals this packet's delay, total bytes fit the byte-count width
    a_first_pkt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.direction_packets == 64'd1) |->
            (m_data.direction_total_delay == {32'd0, m_data.delay_us}) &&
            (m_data.direction_total_bytes[63:nictd_pkg::BYTES_W] == '0))
        else $error("first packet totals inconsistent");

endmodule

bind nic_transfer_delay_model nictd_checker u_nictd_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
